/* sv/gdn_pkg.sv */
// Shared types, constants and character classes of the grouped decimal number recognizer.
`default_nettype none
package gdn_pkg;

  localparam int CHAR_W = 21;

  localparam int unsigned GROUP_SIZE = 3;
  localparam logic [2:0] LEAD_SAT = 3'd4;
  localparam logic [2:0] LEAD_MAX = 3'(GROUP_SIZE);
  localparam logic [1:0] GROUP_MAX = 2'(GROUP_SIZE);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 21'h00002D;
  localparam logic [CHAR_W-1:0] CHAR_DOT = 21'h00002E;
  localparam logic [CHAR_W-1:0] CHAR_NBSP = 21'h0000A0;
  localparam logic [CHAR_W-1:0] CHAR_NONE = 21'h000000;

  localparam logic [CHAR_W-1:0] DECIMAL_MARK_RST = 21'd46;
  localparam logic [CHAR_W-1:0] GROUP_MARK_RST = 21'd0;

  localparam logic CFG_DECIMAL_MARK = 1'b0;
  localparam logic CFG_GROUP_MARK = 1'b1;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_SIGNSP,
    PH_INT,
    PH_GRP,
    PH_FRAC0,
    PH_FRAC,
    PH_TRAIL
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] lead_digits;
    logic [1:0] group_digits;
    logic       space_pending;
    logic       failed;
  } scan_state_t;

  localparam scan_state_t SCAN_RST = '{
    phase: PH_LEAD,
    lead_digits: 3'd0,
    group_digits: 2'd0,
    space_pending: 1'b0,
    failed: 1'b0
  };

  typedef struct packed {
    logic              out_valid;
    logic [CHAR_W-1:0] out_char;
    logic              done_res;
    logic              is_number;
  } scan_result_t;

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return c inside {[21'h09 : 21'h0D], 21'h20, CHAR_NBSP};
  endfunction

  function automatic logic is_dig(input logic [CHAR_W-1:0] c);
    return c inside {[21'h30 : 21'h39]};
  endfunction

endpackage
`default_nettype wire

/* sv/gdn_step.sv */
// Next-state and emit logic for one character of the number scanner.
`default_nettype none
module gdn_step (
  input  wire gdn_pkg::scan_state_t           cur,
  input  wire logic [gdn_pkg::CHAR_W-1:0]     in_char,
  input  wire logic                           last,
  input  wire logic [gdn_pkg::CHAR_W-1:0]     decimal_mark,
  input  wire logic [gdn_pkg::CHAR_W-1:0]     group_mark,
  output gdn_pkg::scan_state_t                nxt,
  output gdn_pkg::scan_result_t               res
);
  import gdn_pkg::*;

  logic   dm_on;
  logic   gm_on;
  logic   gm_ws;
  logic   marks_equal;
  logic   c_dig;
  logic   c_ws;
  logic   c_group;
  logic   c_decimal;
  logic   taken;
  logic   group_ok;
  logic   after_int;
  logic   ok;
  phase_t ph;

  assign dm_on = decimal_mark != CHAR_NONE;
  assign gm_on = group_mark != CHAR_NONE;
  assign gm_ws = is_ws(group_mark);
  assign marks_equal = dm_on && (decimal_mark == group_mark);
  assign c_dig = is_dig(in_char);
  assign c_ws = is_ws(in_char);
  assign c_group = gm_on && (in_char == group_mark);
  assign c_decimal = dm_on && (in_char == decimal_mark);

  always_comb begin
    nxt = cur;
    res = '0;
    taken = 1'b0;
    group_ok = 1'b0;
    after_int = 1'b0;
    ph = cur.phase;
    ok = 1'b0;

    if (!cur.failed) begin
      // a pending whitespace separator resolves on this character
      if (cur.space_pending) begin
        nxt.space_pending = 1'b0;
        if (c_dig) begin
          taken = 1'b1;
          if (cur.phase == PH_INT && cur.lead_digits > LEAD_MAX) begin
            nxt.failed = 1'b1;
          end else begin
            nxt.phase = PH_GRP;
            nxt.group_digits = 2'd1;
            res.out_valid = 1'b1;
            res.out_char = in_char;
          end
        end else if (marks_equal) begin
          taken = 1'b1;
          nxt.failed = 1'b1;
        end else begin
          ph = PH_TRAIL;
          nxt.phase = PH_TRAIL;
        end
      end

      if (!taken) begin
        case (ph)
          PH_LEAD: begin
            if (c_ws) begin
              nxt.phase = PH_LEAD;
            end else if (in_char == CHAR_MINUS) begin
              res.out_valid = 1'b1;
              res.out_char = in_char;
              nxt.phase = PH_SIGN;
            end else if (c_dig) begin
              res.out_valid = 1'b1;
              res.out_char = in_char;
              nxt.lead_digits = 3'd1;
              nxt.phase = PH_INT;
            end else begin
              nxt.failed = 1'b1;
            end
          end
          PH_SIGN, PH_SIGNSP: begin
            if (c_dig) begin
              res.out_valid = 1'b1;
              res.out_char = in_char;
              nxt.lead_digits = 3'd1;
              nxt.phase = PH_INT;
            end else if (ph == PH_SIGN && c_ws) begin
              nxt.phase = PH_SIGNSP;
            end else begin
              nxt.failed = 1'b1;
            end
          end
          PH_INT: begin
            if (c_dig) begin
              res.out_valid = 1'b1;
              res.out_char = in_char;
              if (cur.lead_digits <= LEAD_MAX) begin
                nxt.lead_digits = cur.lead_digits + 3'd1;
              end
            end else begin
              after_int = 1'b1;
              group_ok = cur.lead_digits <= LEAD_MAX;
            end
          end
          PH_GRP: begin
            if (cur.group_digits < GROUP_MAX) begin
              if (c_dig) begin
                res.out_valid = 1'b1;
                res.out_char = in_char;
                nxt.group_digits = cur.group_digits + 2'd1;
              end else begin
                nxt.failed = 1'b1;
              end
            end else begin
              after_int = 1'b1;
              group_ok = 1'b1;
            end
          end
          PH_FRAC0, PH_FRAC: begin
            if (c_dig) begin
              res.out_valid = 1'b1;
              res.out_char = in_char;
              nxt.phase = PH_FRAC;
            end else if (ph == PH_FRAC && c_ws) begin
              nxt.phase = PH_TRAIL;
            end else begin
              nxt.failed = 1'b1;
            end
          end
          PH_TRAIL: begin
            if (!c_ws) begin
              nxt.failed = 1'b1;
            end
          end
          default: begin
            nxt.failed = 1'b1;
          end
        endcase

        // character after a complete integer part: group mark wins over decimal mark
        if (after_int) begin
          if (c_group) begin
            if (gm_ws) begin
              nxt.space_pending = 1'b1;
            end else if (!group_ok) begin
              nxt.failed = 1'b1;
            end else begin
              nxt.phase = PH_GRP;
              nxt.group_digits = 2'd0;
            end
          end else if (c_decimal) begin
            res.out_valid = 1'b1;
            res.out_char = CHAR_DOT;
            nxt.phase = PH_FRAC0;
          end else if (c_ws) begin
            nxt.phase = PH_TRAIL;
          end else begin
            nxt.failed = 1'b1;
          end
        end
      end
    end

    // drop the emitted character on the word that fails
    if (nxt.failed) begin
      res.out_valid = 1'b0;
      res.out_char = CHAR_NONE;
    end

    if (!nxt.failed) begin
      if (nxt.phase == PH_INT || (nxt.phase == PH_GRP && nxt.group_digits >= GROUP_MAX)) begin
        ok = nxt.space_pending ? !marks_equal : 1'b1;
      end else begin
        ok = nxt.phase == PH_FRAC || nxt.phase == PH_TRAIL;
      end
    end

    res.done_res = last;
    if (last) begin
      res.is_number = ok;
      nxt = SCAN_RST;
    end
  end

endmodule
`default_nettype wire

/* sv/grouped_decimal_number_recognizer.sv */
// Top level of the grouped decimal number recognizer: stream ports, registers and config.
// Path: an accepted input word goes into the input register, then through the scanner logic
//   into the result register, which drives its result word on the master side.
// Throughput: one word per cycle while the master side takes results; the scanner state updates once per character.
// Reset (rst, synchronous, active high): empties both registers, returns the scanner to the
//   leading-whitespace phase, sets decimal_mark to '.' and group_mark to 0 (grouping off).
`default_nettype none
module grouped_decimal_number_recognizer (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream: tdata = in_char[20:0], zero padded to 24 bits; tlast = last
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,
  input  wire logic        s_tlast,
  // result stream: tdata = out_valid[0], out_char[21:1], is_number[22], zero pad[23];
  // tlast = done_res
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,
  output logic             m_tlast,
  // configuration writes: index 0 = decimal_mark, index 1 = group_mark
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [20:0] cfg_data
);
  import gdn_pkg::*;

  // configuration registers
  logic [CHAR_W-1:0] decimal_mark;
  logic [CHAR_W-1:0] group_mark;

  // input register
  logic              in_v;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  // scanner state
  scan_state_t       scan;
  scan_state_t       scan_next;
  scan_result_t      step_res;

  // result register
  scan_result_t      out_res;

  logic              advance;

  // Registers are to be written only while idle; the block itself does not enforce this, so always take the write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimal_mark <= DECIMAL_MARK_RST;
      group_mark <= GROUP_MARK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DECIMAL_MARK: decimal_mark <= cfg_data;
        CFG_GROUP_MARK:   group_mark <= cfg_data;
        default:          decimal_mark <= decimal_mark;
      endcase
    end
  end

  // Advance the held word into the result register whenever that register is free or
  // being drained this cycle; the input side refills in the same cycle.
  assign advance = in_v && (!m_tvalid || m_tready);
  assign s_tready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata[CHAR_W-1:0];
      in_last <= s_tlast;
    end
  end

  gdn_step u_step (
    .cur          (scan),
    .in_char      (in_char),
    .last         (in_last),
    .decimal_mark (decimal_mark),
    .group_mark   (group_mark),
    .nxt          (scan_next),
    .res          (step_res)
  );

  // Scanner state moves only when a character is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= SCAN_RST;
    end else if (advance) begin
      scan <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {1'b0, out_res.is_number, out_res.out_char, out_res.out_valid};
  assign m_tlast = out_res.done_res;

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench of the grouped decimal number recognizer: random texts, streams, marks.
`timescale 1ns / 100ps
module tb_top;
  import gdn_pkg::*;

  // Cycles without any input, result or register-write handshake before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;
  // Least number of input words per mark setting in the random part.
  localparam int WORDS_PER_SETTING = 150;
  localparam int NUM_SETTINGS = 11;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              lst;
  } char_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_DECIMAL_MARK;
  logic [20:0] cfg_data = '0;

  grouped_decimal_number_recognizer dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Character words waiting to be offered, and the result words they must produce.
  char_word_t   pending_chars[$];
  scan_result_t results_expected[$];
  logic [CHAR_W-1:0] text_buf[$];

  // Scanner shadow: marks as last written, and the recognizer state.
  logic [CHAR_W-1:0] dec_mark_m = DECIMAL_MARK_RST;
  logic [CHAR_W-1:0] grp_mark_m = GROUP_MARK_RST;
  phase_t            sc_phase = PH_LEAD;
  int                sc_lead = 0;
  int                sc_grp = 0;
  bit                sc_pend = 1'b0;
  bit                sc_fail = 1'b0;
  bit                em_v;
  logic [CHAR_W-1:0] em_c;

  // Run statistics.
  int mismatches = 0;
  int texts_sent = 0;
  int words_in = 0;
  int results_seen = 0;
  int numbers_seen = 0;
  int cfg_writes = 0;
  int setting_words = 0;
  int idle_cycles = 0;
  bit in_fire = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- scanner shadow

  function automatic bit space_code(logic [CHAR_W-1:0] c);
    return (c >= 21'h09 && c <= 21'h0D) || c == 21'h20 || c == CHAR_NBSP;
  endfunction

  function automatic bit digit_code(logic [CHAR_W-1:0] c);
    return c >= 21'h30 && c <= 21'h39;
  endfunction

  function automatic void put_out(logic [CHAR_W-1:0] c);
    em_v = 1'b1;
    em_c = c;
  endfunction

  function automatic void clear_scan();
    sc_phase = PH_LEAD;
    sc_lead = 0;
    sc_grp = 0;
    sc_pend = 1'b0;
    sc_fail = 1'b0;
  endfunction

  // Character right after a complete integer part: group mark first, then decimal mark.
  function automatic void close_integer(logic [CHAR_W-1:0] c, bit group_ok);
    if (grp_mark_m != 0 && c == grp_mark_m) begin
      if (space_code(grp_mark_m)) sc_pend = 1'b1;
      else if (!group_ok) sc_fail = 1'b1;
      else begin
        sc_phase = PH_GRP;
        sc_grp = 0;
      end
    end else if (dec_mark_m != 0 && c == dec_mark_m) begin
      put_out(CHAR_DOT);
      sc_phase = PH_FRAC0;
    end else if (space_code(c)) begin
      sc_phase = PH_TRAIL;
    end else begin
      sc_fail = 1'b1;
    end
  endfunction

  function automatic void scan_char(logic [CHAR_W-1:0] c);
    // A whitespace group mark only counts when a digit follows it.
    if (sc_pend) begin
      sc_pend = 1'b0;
      if (digit_code(c)) begin
        if (sc_phase == PH_INT && sc_lead > GROUP_SIZE) sc_fail = 1'b1;
        else begin
          sc_phase = PH_GRP;
          sc_grp = 1;
          put_out(c);
        end
        return;
      end
      if (dec_mark_m != 0 && dec_mark_m == grp_mark_m) begin
        sc_fail = 1'b1;
        return;
      end
      sc_phase = PH_TRAIL;
    end
    case (sc_phase)
      PH_LEAD: begin
        if (space_code(c)) begin
        end else if (c == CHAR_MINUS) begin
          put_out(c);
          sc_phase = PH_SIGN;
        end else if (digit_code(c)) begin
          put_out(c);
          sc_lead = 1;
          sc_phase = PH_INT;
        end else sc_fail = 1'b1;
      end
      PH_SIGN, PH_SIGNSP: begin
        if (digit_code(c)) begin
          put_out(c);
          sc_lead = 1;
          sc_phase = PH_INT;
        end else if (sc_phase == PH_SIGN && space_code(c)) sc_phase = PH_SIGNSP;
        else sc_fail = 1'b1;
      end
      PH_INT: begin
        if (digit_code(c)) begin
          put_out(c);
          if (sc_lead <= GROUP_SIZE) sc_lead++;
        end else close_integer(c, sc_lead <= GROUP_SIZE);
      end
      PH_GRP: begin
        if (sc_grp < GROUP_SIZE) begin
          if (digit_code(c)) begin
            put_out(c);
            sc_grp++;
          end else sc_fail = 1'b1;
        end else close_integer(c, 1'b1);
      end
      PH_FRAC0, PH_FRAC: begin
        if (digit_code(c)) begin
          put_out(c);
          sc_phase = PH_FRAC;
        end else if (sc_phase == PH_FRAC && space_code(c)) sc_phase = PH_TRAIL;
        else sc_fail = 1'b1;
      end
      PH_TRAIL: begin
        if (!space_code(c)) sc_fail = 1'b1;
      end
      default: sc_fail = 1'b1;
    endcase
  endfunction

  function automatic bit text_matches();
    if (sc_fail) return 1'b0;
    if (sc_phase == PH_INT || (sc_phase == PH_GRP && sc_grp >= GROUP_SIZE)) begin
      if (sc_pend) return !(dec_mark_m != 0 && dec_mark_m == grp_mark_m);
      return 1'b1;
    end
    return sc_phase == PH_FRAC || sc_phase == PH_TRAIL;
  endfunction

  // Advance the shadow by one character and return the result word it must cause.
  function automatic scan_result_t predict_word(logic [CHAR_W-1:0] c, logic lst);
    scan_result_t r;
    em_v = 1'b0;
    em_c = CHAR_NONE;
    if (!sc_fail) scan_char(c);
    if (sc_fail) begin
      em_v = 1'b0;
      em_c = CHAR_NONE;
    end
    r.out_valid = em_v;
    r.out_char = em_v ? em_c : CHAR_NONE;
    r.done_res = lst;
    r.is_number = lst ? text_matches() : 1'b0;
    if (lst) clear_scan();
    return r;
  endfunction

  // ---------------------------------------------------------------- text generation

  // Append one character to the text being built.
  function automatic void add_char(logic [CHAR_W-1:0] c);
    text_buf = {text_buf, c};
  endfunction

  function automatic logic [CHAR_W-1:0] rand_digit();
    return 21'h30 + 21'($urandom_range(0, 9));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_space();
    case ($urandom_range(0, 6))
      0: return 21'h09;
      1: return 21'h0A;
      2: return 21'h0B;
      3: return 21'h0C;
      4: return 21'h0D;
      5: return 21'h20;
      default: return CHAR_NBSP;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] noise_char();
    case ($urandom_range(0, 5))
      0: return 21'($urandom);
      1: return 21'($urandom_range(32, 126));
      2: return CHAR_NONE;
      3: return 21'h1FFFFF;
      4: return dec_mark_m;
      default: return grp_mark_m;
    endcase
  endfunction

  // Queue the buffered text for the sender, marking its final character as last.
  task automatic flush_text();
    char_word_t w;
    if (text_buf.size() == 0) add_char(rand_digit());
    foreach (text_buf[i]) begin
      w.ch = text_buf[i];
      w.lst = (i == text_buf.size() - 1);
      pending_chars = {pending_chars, w};
    end
    setting_words += text_buf.size();
    texts_sent++;
    text_buf.delete();
  endtask

  task automatic send_ascii(input string s);
    for (int i = 0; i < s.len(); i++) add_char({13'b0, s[i]});
    flush_text();
  endtask

  // Mostly well-formed numbers for the current marks; some are noise or get broken.
  task automatic gen_text();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) add_char(noise_char());
    end else begin
      repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0)
        add_char(rand_space());
      if ($urandom_range(0, 2) == 0) begin
        add_char(CHAR_MINUS);
        if ($urandom_range(0, 2) == 0) add_char(rand_space());
      end
      if (grp_mark_m != 0 && $urandom_range(0, 2) != 0) begin
        n = ($urandom_range(0, 7) == 0) ? 4 : $urandom_range(1, 3);
        repeat (n) add_char(rand_digit());
        repeat ($urandom_range(1, 3)) begin
          add_char(grp_mark_m);
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 3;
          repeat (n) add_char(rand_digit());
        end
      end else begin
        repeat ($urandom_range(1, 7)) add_char(rand_digit());
      end
      if (dec_mark_m != 0 && $urandom_range(0, 1) == 0) begin
        add_char(dec_mark_m);
        n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
        repeat (n) add_char(rand_digit());
      end
      repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0)
        add_char(rand_space());
      // Break the text at one spot.
      if (kind >= 8) begin
        n = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: text_buf[n] = noise_char();
          1: text_buf.delete(n);
          2: text_buf.insert(n, rand_digit());
          default: text_buf.insert(n, ($urandom_range(0, 1) == 0) ? CHAR_MINUS : rand_space());
        endcase
      end
    end
    flush_text();
  endtask

  function automatic logic [CHAR_W-1:0] pick_mark();
    case ($urandom_range(0, 9))
      0: return CHAR_NONE;
      1: return CHAR_DOT;
      2: return 21'h2C;     // ','
      3: return 21'h20;
      4: return CHAR_NBSP;
      5: return 21'h27;     // apostrophe
      6: return 21'h35;     // '5'
      7: return 21'h09;
      8: return 21'h1FFFFF;
      default: return 21'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- config and phases

  task automatic write_mark(input logic idx, input logic [CHAR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DECIMAL_MARK) dec_mark_m = val;
    else grp_mark_m = val;
    cfg_writes++;
  endtask

  task automatic set_marks(input logic [CHAR_W-1:0] dm, input logic [CHAR_W-1:0] gm);
    write_mark(CFG_DECIMAL_MARK, dm);
    write_mark(CFG_GROUP_MARK, gm);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every queued word went in and every result came back, plus the pipeline.
  task automatic wait_idle();
    while (pending_chars.size() != 0 || results_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input scan_result_t want,
                                 input scan_result_t got);
    mismatches++;
    $display("[%0t] %s: want v=%0b c=%h d=%0b n=%0b, got v=%0b c=%h d=%0b n=%0b",
             $time, what, want.out_valid, want.out_char, want.done_res, want.is_number,
             got.out_valid, got.out_char, got.done_res, got.is_number);
  endtask

  initial begin : stimulus
    logic [CHAR_W-1:0] dm;
    logic [CHAR_W-1:0] gm;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed texts under the reset marks ('.' decimal, no grouping).
    send_ascii("0");
    send_ascii("-12.5");
    send_ascii(" - 7\t");     // sign followed by one whitespace
    send_ascii("--1");
    send_ascii("1.");         // decimal mark with no fraction digit
    add_char(21'h1FFFFF);
    flush_text();
    add_char(CHAR_NBSP);
    add_char(21'h39);
    flush_text();
    wait_idle();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0: begin dm = CHAR_DOT; gm = 21'h2C; end
        1: begin dm = 21'h2C; gm = 21'h20; end
        2: begin dm = 21'h2C; gm = CHAR_NBSP; end
        3: begin dm = CHAR_NONE; gm = CHAR_NONE; end
        4: begin dm = 21'h1FFFFF; gm = 21'h1FFFFE; end
        5: begin dm = 21'h20; gm = 21'h20; end        // same whitespace for both marks
        6: begin dm = 21'h35; gm = 21'h27; end        // digit as decimal mark
        7: begin dm = CHAR_DOT; gm = CHAR_DOT; end    // group mark wins
        8: begin dm = DECIMAL_MARK_RST; gm = GROUP_MARK_RST; end
        default: begin dm = pick_mark(); gm = pick_mark(); end
      endcase
      set_marks(dm, gm);
      setting_words = 0;
      if (p == 1) begin
        send_ascii("1234 567");   // too many lead digits before a space group mark
        send_ascii("12 345,5");
      end
      while (setting_words < WORDS_PER_SETTING) gen_text();
      wait_idle();
    end

    foreach (results_expected[i])
      report_mismatch("result never arrived", results_expected[i], '0);
    $display("Covered %0d texts of %0d characters over %0d mark settings, %0d register writes.",
             texts_sent, words_in, NUM_SETTINGS + 1, cfg_writes);
    $display("%0d results checked, %0d texts recognized as numbers, %0d mismatches.",
             results_seen, numbers_seen, mismatches);
    if (mismatches == 0 && results_expected.size() == 0)
      $display("grouped_decimal_number_recognizer verification clean");
    else
      $display("grouped_decimal_number_recognizer verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- sender

  // Offer words in bursts with random gaps; hold a word until it is taken.
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_fire) begin
      // hold the offered word
    end else if (gap_left > 0) begin
      gap_left--;
      s_tvalid <= 1'b0;
    end else if (pending_chars.size() != 0) begin
      s_tvalid <= 1'b1;
      s_tdata <= {3'b0, pending_chars[0].ch};
      s_tlast <= pending_chars[0].lst;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- receiver

  // Stall in modes of random length; once, hold off long while the sender keeps offering.
  int  ready_mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!long_hold_done && results_seen > 300 && pending_chars.size() > 60) begin
      long_hold_done = 1'b1;
      hold_left = 300;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 60);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor and watchdog

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    bit busy;
    in_fire = 1'b0;
    if (!rst) begin
      busy = 1'b0;
      if (m_tvalid && m_tready) begin
        busy = 1'b1;
        got = '{m_tdata[0], m_tdata[21:1], m_tlast, m_tdata[22]};
        results_seen++;
        if (results_expected.size() == 0) begin
          report_mismatch("result word with nothing expected", '0, got);
        end else begin
          want = results_expected.pop_front();
          if (want.is_number) numbers_seen++;
          if (got !== want) report_mismatch("wrong result word", want, got);
        end
      end
      // Predict on the word as it stood on the bus at this edge.
      if (s_tvalid && s_tready) begin
        busy = 1'b1;
        in_fire = 1'b1;
        pending_chars.delete(0);
        results_expected = {results_expected, predict_word(s_tdata[20:0], s_tlast)};
        words_in++;
      end
      if (cfg_valid && cfg_ready) busy = 1'b1;
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
        $display("grouped_decimal_number_recognizer verification failed");
        $finish;
      end
    end
  end

endmodule

/* grouped_decimal_number_recognizer.f */
sv/gdn_pkg.sv
sv/gdn_step.sv
sv/grouped_decimal_number_recognizer.sv
sim/tb_top.sv
